### rtl/exr_pkg.sv
// Shared types, constants and helpers for the Euler xyz vector rotator.
package exr_pkg;

  localparam int TRIG_ITERATIONS = 16;
  localparam int NUM_ITER = (TRIG_ITERATIONS < 32) ? TRIG_ITERATIONS : 32;
  localparam int SHIFT_W = 5;
  localparam logic signed [33:0] GAIN_Q30 = 34'sh026DD3B6A;
  localparam int COMP_W = 36;

  typedef struct packed {
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
    logic signed [15:0] angle_x;
    logic signed [15:0] angle_y;
    logic signed [15:0] angle_z;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] rot_x;
    logic signed [31:0] rot_y;
    logic signed [31:0] rot_z;
    logic               saturated;
  } out_word_t;

  // Three parallel CORDIC lanes, one per axis.
  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [32:0] z;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]               lane;
    logic [2:0]                flip;
    logic signed [31:0]        vx;
    logic signed [31:0]        vy;
    logic signed [31:0]        vz;
    logic                      valid;
  } cell_t;

  function automatic logic signed [32:0] atan_turn(input logic [SHIFT_W-1:0] i);
    logic signed [32:0] r;
    case (i)
      5'd0: r = 33'sd536870912;  5'd1: r = 33'sd316933406;
      5'd2: r = 33'sd167458907;  5'd3: r = 33'sd85004756;
      5'd4: r = 33'sd42667331;   5'd5: r = 33'sd21354465;
      5'd6: r = 33'sd10679838;   5'd7: r = 33'sd5340245;
      5'd8: r = 33'sd2670675;    5'd9: r = 33'sd1335343;
      5'd10: r = 33'sd667544;    5'd11: r = 33'sd333772;
      5'd12: r = 33'sd166886;    5'd13: r = 33'sd83443;
      5'd14: r = 33'sd41721;     5'd15: r = 33'sd20860;
      5'd16: r = 33'sd10430;     5'd17: r = 33'sd5215;
      5'd18: r = 33'sd2607;      5'd19: r = 33'sd1303;
      5'd20: r = 33'sd651;       5'd21: r = 33'sd325;
      5'd22: r = 33'sd162;       5'd23: r = 33'sd81;
      5'd24: r = 33'sd40;        5'd25: r = 33'sd20;
      5'd26: r = 33'sd10;        5'd27: r = 33'sd5;
      5'd28: r = 33'sd2;         5'd29: r = 33'sd1;
      default: r = 33'sd0;
    endcase
    return r;
  endfunction

  // floor((v*t + 2^29) / 2^30); v up to 36 bits, t 34 bits
  function automatic logic signed [COMP_W-1:0] mulq(input logic signed [COMP_W-1:0] v,
                                                    input logic signed [33:0] t);
    logic signed [69:0] p;
    p = 70'(v) * 70'(t) + 70'sd536870912;
    return COMP_W'(p >>> 30);
  endfunction

endpackage

### rtl/exr_cordic_cell.sv
// One CORDIC micro-rotation step applied to all three angle lanes.
module exr_cordic_cell (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [exr_pkg::SHIFT_W-1:0]      step,
  input  exr_pkg::cell_t                   din,
  output exr_pkg::cell_t                   dout
);

  exr_pkg::cell_t nxt;
  logic signed [32:0] at;

  always_comb begin
    at = exr_pkg::atan_turn(step);
    nxt = din;
    nxt.valid = din.valid && !rst;
    for (int k = 0; k < 3; k++) begin
      if (!din.lane[k].z[32]) begin
        nxt.lane[k].x = din.lane[k].x - (din.lane[k].y >>> step);
        nxt.lane[k].y = din.lane[k].y + (din.lane[k].x >>> step);
        nxt.lane[k].z = din.lane[k].z - at;
      end else begin
        nxt.lane[k].x = din.lane[k].x + (din.lane[k].y >>> step);
        nxt.lane[k].y = din.lane[k].y - (din.lane[k].x >>> step);
        nxt.lane[k].z = din.lane[k].z + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    dout <= nxt;
  end

endmodule

### rtl/exr_rotate_stage.sv
// One axis rotation: four products, a register, then the sum pair.
module exr_rotate_stage (
  input  logic                              clk,
  input  logic signed [exr_pkg::COMP_W-1:0] a,
  input  logic signed [exr_pkg::COMP_W-1:0] b,
  input  logic signed [33:0]                s,
  input  logic signed [33:0]                c,
  input  logic                              neg_first,
  output logic signed [exr_pkg::COMP_W-1:0] ra,
  output logic signed [exr_pkg::COMP_W-1:0] rb
);

  // neg_first=0: ra = a*c - b*s, rb = a*s + b*c
  // neg_first=1: ra = a*c + b*s, rb = b*c - a*s
  logic signed [exr_pkg::COMP_W-1:0] ac, bs, as_, bc;
  logic neg;

  always_ff @(posedge clk) begin
    ac <= exr_pkg::mulq(a, c);
    bs <= exr_pkg::mulq(b, s);
    as_ <= exr_pkg::mulq(a, s);
    bc <= exr_pkg::mulq(b, c);
    neg <= neg_first;
  end

  always_ff @(posedge clk) begin
    if (neg) begin
      ra <= ac + bs;
      rb <= bc - as_;
    end else begin
      ra <= ac - bs;
      rb <= as_ + bc;
    end
  end

endmodule

### rtl/euler_xyz_vector_rotate_top.sv
// Top level: CORDIC cell chain for three angles, then x, y, z rotation stages.
// One word accepted every cycle (busy stays low); each result appears on the
// result ports for one cycle with done high, after the input register, CORDIC
// cell chain, sine/cosine register, x, y and z rotation stages and the output
// saturation register. Results cannot be held off.
module euler_xyz_vector_rotate_top (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  exr_pkg::in_word_t din,
  output logic              busy,
  output logic              done,
  output exr_pkg::out_word_t dout
);

  localparam int N = exr_pkg::NUM_ITER;
  localparam int W = exr_pkg::COMP_W;

  exr_pkg::cell_t chain [0:N];
  exr_pkg::cell_t head;
  logic acc;

  assign busy = 1'b0;
  assign acc = start && !busy;

  always_comb begin
    logic [15:0] ang [3];
    logic [31:0] a;
    ang[0] = din.angle_x;
    ang[1] = din.angle_y;
    ang[2] = din.angle_z;
    head.vx = din.vec_x;
    head.vy = din.vec_y;
    head.vz = din.vec_z;
    head.valid = acc && !rst;
    for (int k = 0; k < 3; k++) begin
      a = {ang[k], 16'h0000};
      head.flip[k] = a[31] ^ a[30];
      if (head.flip[k]) a = a + 32'h8000_0000;
      head.lane[k].x = exr_pkg::GAIN_Q30;
      head.lane[k].y = 34'sd0;
      head.lane[k].z = 33'(signed'(a));
    end
  end

  always_ff @(posedge clk) begin
    chain[0] <= head;
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    exr_cordic_cell u_cell (
      .clk(clk), .rst(rst), .step(exr_pkg::SHIFT_W'(g)),
      .din(chain[g]), .dout(chain[g+1])
    );
  end

  // Final sine/cosine with quadrant flip, plus delayed vector.
  logic signed [33:0] s0, c0, s1, c1, s2, c2;
  logic signed [33:0] s1d [2], c1d [2], s2d [4], c2d [4];
  logic signed [W-1:0] x0, y0, z0, xd [2];
  logic [7:0] vld;

  always_ff @(posedge clk) begin
    exr_pkg::cell_t t;
    t = chain[N];
    s0 <= t.flip[0] ? -t.lane[0].y : t.lane[0].y;
    c0 <= t.flip[0] ? -t.lane[0].x : t.lane[0].x;
    s1 <= t.flip[1] ? -t.lane[1].y : t.lane[1].y;
    c1 <= t.flip[1] ? -t.lane[1].x : t.lane[1].x;
    s2 <= t.flip[2] ? -t.lane[2].y : t.lane[2].y;
    c2 <= t.flip[2] ? -t.lane[2].x : t.lane[2].x;
    x0 <= W'(t.vx);
    y0 <= W'(t.vy);
    z0 <= W'(t.vz);
    s1d[0] <= s1; s1d[1] <= s1d[0];
    c1d[0] <= c1; c1d[1] <= c1d[0];
    s2d[0] <= s2; c2d[0] <= c2;
    for (int k = 1; k < 4; k++) begin
      s2d[k] <= s2d[k-1];
      c2d[k] <= c2d[k-1];
    end
    xd[0] <= x0; xd[1] <= xd[0];
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[6:0], chain[N].valid};
  end

  logic signed [W-1:0] y1, z1, x2, z2, x3, y3, y1d [2], z2d [2];

  exr_rotate_stage u_rx (.clk(clk), .a(y0), .b(z0), .s(s0), .c(c0),
    .neg_first(1'b0), .ra(y1), .rb(z1));
  exr_rotate_stage u_ry (.clk(clk), .a(xd[1]), .b(z1), .s(s1d[1]), .c(c1d[1]),
    .neg_first(1'b1), .ra(x2), .rb(z2));
  exr_rotate_stage u_rz (.clk(clk), .a(x2), .b(y1d[1]), .s(s2d[3]), .c(c2d[3]),
    .neg_first(1'b0), .ra(x3), .rb(y3));

  always_ff @(posedge clk) begin
    y1d[0] <= y1; y1d[1] <= y1d[0];
    z2d[0] <= z2; z2d[1] <= z2d[0];
  end

  function automatic logic [32:0] clip(input logic signed [W-1:0] v);
    if (v > W'(64'sd2147483647)) return {1'b1, 32'h7FFF_FFFF};
    if (v < -W'(64'sd2147483648)) return {1'b1, 32'h8000_0000};
    return {1'b0, v[31:0]};
  endfunction

  function automatic logic at_bound(input logic [31:0] v);
    return (v == 32'h7FFF_FFFF) || (v == 32'h8000_0000);
  endfunction

  always_ff @(posedge clk) begin
    logic [32:0] cx, cy, cz;
    cx = clip(x3);
    cy = clip(y3);
    cz = clip(z2d[1]);
    dout.rot_x <= cx[31:0];
    dout.rot_y <= cy[31:0];
    dout.rot_z <= cz[31:0];
    dout.saturated <= cx[32] | cy[32] | cz[32];
  end

  assign done = vld[7];

  a_lat: assert property (@(posedge clk) disable iff (rst)
    chain[0].valid |-> ##(N + 8) done) else $error("result latency broken");
  a_sat: assert property (@(posedge clk) disable iff (rst)
    (done && dout.saturated) |->
      (at_bound(dout.rot_x) || at_bound(dout.rot_y) || at_bound(dout.rot_z)))
    else $error("saturation flag");
  a_nobusy: assert property (@(posedge clk) !busy) else $error("busy asserted");

endmodule
